[rtl/lctm_pkg.sv]
package lctm_pkg;

  // defaults for the top level parameters
  localparam int CHANNELS_DEF    = 4;
  localparam int ENTRIES_DEF     = 8;
  localparam int CODE_BITS_DEF   = 32;

  // register reset values
  localparam logic [2:0]  RST_CHANNELS_IN_USE = 3'd4;
  localparam logic [15:0] RST_REPEAT_WINDOW   = 16'd300;
  localparam logic [15:0] RST_MODE_TIMEOUT    = 16'd10000;

  // register indexes
  localparam logic [1:0] CFG_CHANNELS_IN_USE = 2'd0;
  localparam logic [1:0] CFG_REPEAT_WINDOW   = 2'd1;
  localparam logic [1:0] CFG_MODE_TIMEOUT    = 2'd2;

  // request op codes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_CODE       = 3'd1;
  localparam logic [2:0] OP_LEARN      = 3'd2;
  localparam logic [2:0] OP_DELETE     = 3'd3;
  localparam logic [2:0] OP_DELETE_ALL = 3'd4;

  // result events
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_REPEAT   = 4'd1;
  localparam logic [3:0] EV_MATCH    = 4'd2;
  localparam logic [3:0] EV_NOMATCH  = 4'd3;
  localparam logic [3:0] EV_LEARNED  = 4'd4;
  localparam logic [3:0] EV_KNOWN    = 4'd5;
  localparam logic [3:0] EV_DELETED  = 4'd6;
  localparam logic [3:0] EV_DEL_MISS = 4'd7;
  localparam logic [3:0] EV_TIMEOUT  = 4'd8;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LEARN  = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_SHIFT = 2'd2,
    ST_OUT   = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]  channels_in_use;
    logic [15:0] repeat_window;
    logic [15:0] mode_timeout;
  } cfg_t;

endpackage

[rtl/lctm_code_ram.sv]
module lctm_code_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lctm_cfg_regs.sv]
module lctm_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_wdata_i,
  output lctm_pkg::cfg_t    cfg_o
);
  import lctm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channels_in_use <= RST_CHANNELS_IN_USE;
      cfg_q.repeat_window   <= RST_REPEAT_WINDOW;
      cfg_q.mode_timeout    <= RST_MODE_TIMEOUT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CHANNELS_IN_USE: cfg_q.channels_in_use <= cfg_wdata_i[2:0];
        CFG_REPEAT_WINDOW:   cfg_q.repeat_window   <= cfg_wdata_i;
        CFG_MODE_TIMEOUT:    cfg_q.mode_timeout    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/learned_code_table_matcher.sv]
// Learned remote-code table matcher.
// Input stream: tuser = op (tick, code, start learn, start delete, delete all),
// tdata = channel and code. Output stream: tuser = event, tdata = toggle mask.
// Exactly one result per request, in request order.
// Config channel: index/data writes, always ready; write only while idle.
// Timing: tick, start learn/delete, delete all and a repeated code finish on
// the accepting edge; the result is valid the next cycle. A non-repeated code
// walks the code RAM (one read port, registered read), one stored entry per
// cycle. A learn into a full channel or a delete that finds its code adds a
// copy pass through the RAM.
// One request is worked on at a time; a new request is taken in the idle
// state whenever the output register is empty or being drained.
// Reset clears counts, mode, last code and tick counters; the RAM has no
// reset, entries above a channel's count are never read.
// A stalled receiver holds the result in the output register; input tready
// stays low until it can be replaced.
module learned_code_table_matcher #(
  parameter int CHANNELS            = lctm_pkg::CHANNELS_DEF,
  parameter int ENTRIES_PER_CHANNEL = lctm_pkg::ENTRIES_DEF,
  parameter int CODE_BITS           = lctm_pkg::CODE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [1:0] channel, [33:2] code, rest zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] op
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [3:0] toggle_mask, rest zero
  output logic [3:0]  m_axis_tuser_o    // [3:0] event_res
);
  import lctm_pkg::*;

  localparam int EPC   = ENTRIES_PER_CHANNEL;
  localparam int CW    = CODE_BITS;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHC_W = $clog2(CHANNELS + 1);
  localparam int CNT_W = $clog2(EPC + 1);
  localparam int DEPTH = CHANNELS * EPC;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  lctm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // request fields
  logic [2:0]    in_op;
  logic [1:0]    in_ch;
  logic [CW-1:0] in_code;
  assign in_op   = s_axis_tuser_i;
  assign in_ch   = s_axis_tdata_i[1:0];
  assign in_code = CW'(s_axis_tdata_i[33:2]);

  // code RAM
  logic          ram_re, ram_we;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [CW-1:0] ram_rdata, ram_wdata;

  lctm_code_ram #(.DEPTH(DEPTH), .AW(AW), .DW(CW)) u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  function automatic logic [AW-1:0] slot_addr(input logic [CH_W-1:0]  ch,
                                              input logic [CNT_W-1:0] idx);
    slot_addr = AW'(ch) * AW'(EPC) + AW'(idx);
  endfunction

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d, kind_q, kind_d;
  logic [CH_W-1:0]   mode_ch_q, mode_ch_d;
  logic [16:0]       mode_ticks_q, mode_ticks_d;
  logic [CW-1:0]     last_code_q, last_code_d;
  logic [15:0]       tsl_q, tsl_d;
  logic [CNT_W-1:0]  count_q [CHANNELS];
  logic [CNT_W-1:0]  count_d [CHANNELS];

  // scan / copy engine
  logic [CW-1:0]       code_q, code_d;
  logic [CHC_W-1:0]    scan_ch_q, scan_ch_d, scan_end_q, scan_end_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic [CH_W-1:0]     rd_ch_q, rd_ch_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                hit_q, hit_d;
  logic [CNT_W-1:0]    hit_idx_q, hit_idx_d;
  logic [CHANNELS-1:0] mask_q, mask_d;
  logic [CNT_W-1:0]    sh_q, sh_d, sh_end_q, sh_end_d, sh_widx_q, sh_widx_d;
  logic                sh_vld_q, sh_vld_d;
  logic [3:0]          ev_q, ev_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [3:0]          out_ev_q, out_ev_d;
  logic [3:0]          out_mask_q, out_mask_d;

  logic [CHANNELS+3:0] mask_wide;
  logic [CNT_W-1:0]    cnt_k, cnt_scan;
  logic [16:0]         mt_inc;
  logic                out_free;

  assign mask_wide = {4'b0000, mask_q};
  assign cnt_k     = count_q[mode_ch_q];
  assign cnt_scan  = count_q[scan_ch_q[CH_W-1:0]];
  assign mt_inc    = (mode_ticks_q != 17'h1FFFF) ? mode_ticks_q + 17'd1 : mode_ticks_q;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    kind_d       = kind_q;
    mode_ch_d    = mode_ch_q;
    mode_ticks_d = mode_ticks_q;
    last_code_d  = last_code_q;
    tsl_d        = tsl_q;
    count_d      = count_q;
    code_d       = code_q;
    scan_ch_d    = scan_ch_q;
    scan_end_d   = scan_end_q;
    idx_d        = idx_q;
    rd_vld_d     = 1'b0;
    rd_ch_d      = rd_ch_q;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    mask_d       = mask_q;
    sh_d         = sh_q;
    sh_end_d     = sh_end_q;
    sh_widx_d    = sh_widx_q;
    sh_vld_d     = 1'b0;
    ev_d         = ev_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_ev_d     = out_ev_q;
    out_mask_d   = out_mask_q;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = code_q;
    s_axis_tready_o = 1'b0;

    // compare the word read last cycle
    if (rd_vld_q && ram_rdata == code_q) begin
      mask_d[rd_ch_q] = 1'b1;
      if (!hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = rd_idx_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = out_free;
        if (s_axis_tvalid_i && out_free) begin
          // immediate result unless a table walk starts
          out_valid_d = 1'b1;
          out_ev_d    = EV_NONE;
          out_mask_d  = '0;
          case (in_op)
            OP_TICK: begin
              if (tsl_q != 16'hFFFF) tsl_d = tsl_q + 16'd1;
              if (mode_q != MODE_NORMAL) begin
                mode_ticks_d = mt_inc;
                if (mt_inc > {1'b0, cfg.mode_timeout}) begin
                  mode_d   = MODE_NORMAL;
                  out_ev_d = EV_TIMEOUT;
                end
              end
            end
            OP_CODE: begin
              if (in_code == last_code_q && tsl_q < cfg.repeat_window) begin
                out_ev_d = EV_REPEAT;
              end else begin
                out_valid_d = out_valid_q && !m_axis_tready_i;
                last_code_d = in_code;
                tsl_d       = '0;
                code_d      = in_code;
                mask_d      = '0;
                hit_d       = 1'b0;
                idx_d       = '0;
                state_d     = ST_SCAN;
                if (mode_q == MODE_NORMAL) begin
                  kind_d     = MODE_NORMAL;
                  scan_ch_d  = '0;
                  scan_end_d = (int'(cfg.channels_in_use) > CHANNELS) ?
                               CHC_W'(CHANNELS) : CHC_W'(cfg.channels_in_use);
                end else begin
                  kind_d     = mode_q;
                  scan_ch_d  = CHC_W'(mode_ch_q);
                  scan_end_d = CHC_W'(mode_ch_q) + CHC_W'(1);
                  mode_d     = MODE_NORMAL;
                end
              end
            end
            OP_LEARN, OP_DELETE: begin
              if (int'(in_ch) < CHANNELS) begin
                mode_d       = (in_op == OP_LEARN) ? MODE_LEARN : MODE_DELETE;
                mode_ch_d    = CH_W'(in_ch);
                mode_ticks_d = '0;
              end
            end
            OP_DELETE_ALL: begin
              for (int c = 0; c < CHANNELS; c++) count_d[c] = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_ch_q < scan_end_q) begin
          if (idx_q < cnt_scan) begin
            ram_re    = 1'b1;
            ram_raddr = slot_addr(scan_ch_q[CH_W-1:0], idx_q);
            rd_vld_d  = 1'b1;
            rd_ch_d   = scan_ch_q[CH_W-1:0];
            rd_idx_d  = idx_q;
            idx_d     = idx_q + CNT_W'(1);
          end else begin
            scan_ch_d = scan_ch_q + CHC_W'(1);
            idx_d     = '0;
          end
        end else if (!rd_vld_q) begin
          state_d = ST_OUT;
          case (kind_q)
            MODE_NORMAL: ev_d = (|mask_q) ? EV_MATCH : EV_NOMATCH;
            MODE_LEARN: begin
              if (hit_q) begin
                ev_d = EV_KNOWN;
              end else if (int'(cnt_k) < EPC) begin
                ev_d      = EV_LEARNED;
                ram_we    = 1'b1;
                ram_waddr = slot_addr(mode_ch_q, cnt_k);
                count_d[mode_ch_q] = cnt_k + CNT_W'(1);
              end else begin
                // full: drop the oldest, append at the top slot
                ev_d     = EV_LEARNED;
                sh_d     = CNT_W'(1);
                sh_end_d = CNT_W'(EPC);
                state_d  = ST_SHIFT;
              end
            end
            MODE_DELETE: begin
              if (!hit_q) begin
                ev_d = EV_DEL_MISS;
              end else begin
                ev_d     = EV_DELETED;
                sh_d     = hit_idx_q + CNT_W'(1);
                sh_end_d = cnt_k;
                count_d[mode_ch_q] = cnt_k - CNT_W'(1);
                state_d  = ST_SHIFT;
              end
            end
            default: ev_d = EV_NONE;
          endcase
        end
      end

      ST_SHIFT: begin
        // read slot j, write it to j-1 in the next cycle
        if (sh_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = slot_addr(mode_ch_q, sh_widx_q);
          ram_wdata = ram_rdata;
        end
        if (sh_q < sh_end_q) begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(mode_ch_q, sh_q);
          sh_vld_d  = 1'b1;
          sh_widx_d = sh_q - CNT_W'(1);
          sh_d      = sh_q + CNT_W'(1);
        end else if (!sh_vld_q) begin
          if (kind_q == MODE_LEARN) begin
            ram_we    = 1'b1;
            ram_waddr = slot_addr(mode_ch_q, CNT_W'(EPC - 1));
            ram_wdata = code_q;
          end
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ev_d    = ev_q;
          out_mask_d  = (ev_q == EV_MATCH) ? mask_wide[3:0] : 4'b0000;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MODE_NORMAL;
      kind_q       <= MODE_NORMAL;
      mode_ch_q    <= '0;
      mode_ticks_q <= '0;
      last_code_q  <= '0;
      tsl_q        <= '0;
      for (int c = 0; c < CHANNELS; c++) count_q[c] <= '0;
      scan_ch_q    <= '0;
      scan_end_q   <= '0;
      idx_q        <= '0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      sh_q         <= '0;
      sh_end_q     <= '0;
      sh_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      kind_q       <= kind_d;
      mode_ch_q    <= mode_ch_d;
      mode_ticks_q <= mode_ticks_d;
      last_code_q  <= last_code_d;
      tsl_q        <= tsl_d;
      count_q      <= count_d;
      scan_ch_q    <= scan_ch_d;
      scan_end_q   <= scan_end_d;
      idx_q        <= idx_d;
      rd_vld_q     <= rd_vld_d;
      hit_q        <= hit_d;
      sh_q         <= sh_d;
      sh_end_q     <= sh_end_d;
      sh_vld_q     <= sh_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    rd_ch_q    <= rd_ch_d;
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    mask_q     <= mask_d;
    sh_widx_q  <= sh_widx_d;
    ev_q       <= ev_d;
    out_ev_q   <= out_ev_d;
    out_mask_q <= out_mask_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_ev_q;
  assign m_axis_tdata_o  = {4'b0000, out_mask_q};

endmodule

[rtl/lctm_checker.sv]
module lctm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o
);
  import lctm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tuser_o) && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // toggle bits only come with a match
  a_mask_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != EV_MATCH |-> m_axis_tdata_o == 8'h00)
    else $error("toggle mask set without match");

  // non-code requests answer on the next cycle
  a_fast_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i != OP_CODE |=> m_axis_tvalid_o)
    else $error("immediate request gave no result");

  // a request is only taken when the output slot can take its result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("request taken while result stalled");

endmodule

bind learned_code_table_matcher lctm_checker u_lctm_checker (.*);

[sim/learned_code_table_matcher_test.sv]
module learned_code_table_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lctm_pkg::*;

  localparam int NUM_CH  = CHANNELS_DEF;
  localparam int NUM_ENT = ENTRIES_DEF;
  localparam int POOL_SZ = 14;

  // one request on the input stream
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  ch;
    logic [31:0] code;
  } remote_req_t;

  // one result on the output stream
  typedef struct packed {
    logic [3:0] ev;
    logic [3:0] mask;
  } relay_res_t;

  // ---------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = '0;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;  // [1:0] channel, [33:2] code, rest zero
  logic [2:0]  s_axis_tuser_i  = '0;  // [2:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [3:0] toggle_mask, rest zero
  logic [3:0]  m_axis_tuser_o;        // [3:0] event_res

  learned_code_table_matcher uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the code table, mode machine and config registers. Table and
  // mode state update once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [31:0] code_tab [NUM_CH][NUM_ENT];
  int          ent_cnt  [NUM_CH] = '{default: 0};
  mode_e       cur_mode   = MODE_NORMAL;
  logic [1:0]  mode_ch    = '0;
  int          mode_ticks = 0;          // 17-bit saturating
  logic [31:0] last_code  = '0;
  logic [15:0] since_last = '0;         // 16-bit saturating

  logic [2:0]  cfg_channels = RST_CHANNELS_IN_USE;
  logic [15:0] cfg_window   = RST_REPEAT_WINDOW;
  logic [15:0] cfg_timeout  = RST_MODE_TIMEOUT;

  // bookkeeping
  remote_req_t remote_req_q[$];         // requests not yet offered
  relay_res_t  relay_event_q[$];        // predicted results, oldest first
  remote_req_t req_cur    = '0;
  int          queued_n   = 0;
  int          taken_n    = 0;
  int          res_n      = 0;
  int          err_count  = 0;
  int          drv_wait   = 0;
  int          mon_wait   = 0;
  bit          drv_calm   = 1'b0;
  bit          mon_calm   = 1'b0;
  logic [31:0] code_pool [POOL_SZ];
  logic [31:0] last_pushed = '0;

  // index of code v in channel c, -1 when absent; only live entries are read
  function automatic int find_code(int c, logic [31:0] v);
    for (int i = 0; i < ent_cnt[c]; i++)
      if (code_tab[c][i] == v) return i;
    return -1;
  endfunction

  // advance the shadow state by one request and return the result it causes
  function automatic relay_res_t apply_remote_req(remote_req_t rq);
    relay_res_t r;
    int n;
    int hit;
    int lim;
    r.ev   = EV_NONE;
    r.mask = '0;
    case (rq.op)
      OP_TICK: begin
        if (since_last != 16'hFFFF) since_last++;
        if (cur_mode != MODE_NORMAL) begin
          if (mode_ticks < 32'h1FFFF) mode_ticks++;
          if (mode_ticks > int'(cfg_timeout)) begin
            cur_mode = MODE_NORMAL;
            r.ev     = EV_TIMEOUT;
          end
        end
      end
      OP_CODE: begin
        // same code again inside the window: dropped, state untouched
        if (rq.code == last_code && since_last < cfg_window) begin
          r.ev = EV_REPEAT;
        end else begin
          last_code  = rq.code;
          since_last = '0;
          if (cur_mode == MODE_NORMAL) begin
            lim = (int'(cfg_channels) > NUM_CH) ? NUM_CH : int'(cfg_channels);
            for (int c = 0; c < lim; c++)
              if (find_code(c, rq.code) >= 0) r.mask[c] = 1'b1;
            r.ev = (r.mask != '0) ? EV_MATCH : EV_NOMATCH;
          end else begin
            n   = ent_cnt[mode_ch];
            hit = find_code(mode_ch, rq.code);
            if (cur_mode == MODE_LEARN) begin
              if (hit >= 0) begin
                r.ev = EV_KNOWN;
              end else begin
                if (n >= NUM_ENT) begin
                  // full: oldest entry falls out at the bottom
                  for (int j = 0; j < NUM_ENT - 1; j++)
                    code_tab[mode_ch][j] = code_tab[mode_ch][j+1];
                  code_tab[mode_ch][NUM_ENT-1] = rq.code;
                end else begin
                  code_tab[mode_ch][n] = rq.code;
                  ent_cnt[mode_ch]     = n + 1;
                end
                r.ev = EV_LEARNED;
              end
            end else begin
              if (hit < 0) begin
                r.ev = EV_DEL_MISS;
              end else begin
                // close the gap, scan stops at the count
                for (int j = hit; j < n - 1; j++)
                  code_tab[mode_ch][j] = code_tab[mode_ch][j+1];
                ent_cnt[mode_ch] = n - 1;
                r.ev = EV_DELETED;
              end
            end
            cur_mode = MODE_NORMAL;
          end
        end
      end
      OP_LEARN, OP_DELETE: begin
        // a new start replaces any active mode and restarts its timeout
        if (int'(rq.ch) < NUM_CH) begin
          cur_mode   = (rq.op == OP_LEARN) ? MODE_LEARN : MODE_DELETE;
          mode_ch    = rq.ch;
          mode_ticks = 0;
        end
      end
      OP_DELETE_ALL: begin
        foreach (ent_cnt[c]) ent_cnt[c] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < 200) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: pops the pending queue, random gap before each request.
  // Prediction happens on the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : req_driver
    logic send;
    send = s_axis_tvalid_i;
    if (!rst_ni) begin
      send = 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        relay_event_q.push_back(apply_remote_req(req_cur));
        taken_n++;
        send = 1'b0;
        if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
        drv_wait = drv_calm ? 0 : $urandom_range(0, 11);
      end
      if (!send) begin
        if (drv_wait != 0) begin
          drv_wait--;
        end else if (remote_req_q.size() != 0) begin
          req_cur = remote_req_q.pop_front();
          send    = 1'b1;
        end
      end
    end
    s_axis_tvalid_i <= send;
    s_axis_tuser_i  <= req_cur.op;
    s_axis_tdata_i  <= {6'd0, req_cur.code, req_cur.ch};
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random stall after each result, compares against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : res_monitor
    logic       rdy;
    relay_res_t want;
    rdy = m_axis_tready_i;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        res_n++;
        if (relay_event_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", res_n));
        end else begin
          want = relay_event_q.pop_front();
          if (m_axis_tuser_o !== want.ev)
            report_mismatch($sformatf("result %0d event %0d, want %0d",
                                      res_n, m_axis_tuser_o, want.ev));
          if (m_axis_tdata_o[3:0] !== want.mask)
            report_mismatch($sformatf("result %0d toggle mask %b, want %b",
                                      res_n, m_axis_tdata_o[3:0], want.mask));
        end
        if ($urandom_range(0, 39) == 0) mon_calm = !mon_calm;
        mon_wait = mon_calm ? 0 : $urandom_range(0, 11);
        rdy      = (mon_wait == 0);
      end else if (!rdy) begin
        if (mon_wait != 0) mon_wait--;
        if (mon_wait == 0) rdy = 1'b1;
      end
    end
    m_axis_tready_i <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [2:0] op, logic [1:0] ch, logic [31:0] code);
    remote_req_t rq;
    rq.op   = op;
    rq.ch   = ch;
    rq.code = code;
    remote_req_q.push_back(rq);
    queued_n++;
    if (op == OP_CODE) last_pushed = code;
  endtask

  // mostly pool codes so matches, duplicates and full channels show up
  function automatic logic [31:0] pick_code();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) return code_pool[$urandom_range(0, POOL_SZ - 1)];
    if (p < 95) return $urandom;
    return (p < 97) ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  // channel 0 favored so it fills up and starts shifting
  function automatic logic [1:0] pick_ch();
    return ($urandom_range(0, 1) != 0) ? 2'd0 : 2'($urandom_range(0, 3));
  endfunction

  task automatic push_ticks(int n);
    repeat (n) push_req(OP_TICK, 2'($urandom), $urandom);
  endtask

  // wait until every request is taken and answered, plus a short tail
  task automatic wait_drained();
    @(negedge clk_i);
    while (taken_n != queued_n || relay_event_q.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    // ready seen at the falling edge holds through the next rising edge
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CHANNELS_IN_USE: cfg_channels = val[2:0];
      CFG_REPEAT_WINDOW:   cfg_window   = val;
      CFG_MODE_TIMEOUT:    cfg_timeout  = val;
      default: ;
    endcase
  endtask

  // registers only change with the block idle
  task automatic set_regs(logic [2:0] chans, logic [15:0] win, logic [15:0] tmo);
    wait_drained();
    write_reg(CFG_CHANNELS_IN_USE, {13'd0, chans});
    write_reg(CFG_REPEAT_WINDOW, win);
    write_reg(CFG_MODE_TIMEOUT, tmo);
  endtask

  // random part: mostly well-formed learn/delete/match sequences
  task automatic gen_random(int n_items, int burst_max);
    int start_n;
    int p;
    start_n = queued_n;
    while (queued_n - start_n < n_items) begin
      p = $urandom_range(0, 99);
      if (p < 35) begin
        push_req(OP_LEARN, pick_ch(), $urandom);
        if ($urandom_range(0, 4) == 0) push_ticks($urandom_range(1, 2));
        push_req(OP_CODE, 2'($urandom), pick_code());
      end else if (p < 50) begin
        push_req(OP_DELETE, pick_ch(), $urandom);
        if ($urandom_range(0, 4) == 0) push_ticks($urandom_range(1, 2));
        push_req(OP_CODE, 2'($urandom), pick_code());
      end else if (p < 72) begin
        push_req(OP_CODE, 2'($urandom), pick_code());
      end else if (p < 79) begin
        // same code again, possibly after a few ticks
        if ($urandom_range(0, 1) != 0) push_ticks($urandom_range(1, 4));
        push_req(OP_CODE, 2'($urandom), last_pushed);
      end else if (p < 89) begin
        push_ticks($urandom_range(1, burst_max));
      end else if (p < 94) begin
        // start a mode and let it run out
        push_req(($urandom_range(0, 1) != 0) ? OP_LEARN : OP_DELETE, pick_ch(), $urandom);
        push_ticks($urandom_range(1, burst_max));
      end else if (p < 95) begin
        push_req(OP_DELETE_ALL, 2'($urandom), $urandom);
      end else if (p < 97) begin
        push_req(3'($urandom_range(0, 4)), 2'($urandom), $urandom);
      end else begin
        // broken sequence: one start overrides another before the code
        push_req(OP_LEARN, 2'($urandom), $urandom);
        push_req(OP_DELETE, pick_ch(), $urandom);
        push_req(OP_CODE, 2'($urandom), pick_code());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    foreach (code_pool[i]) code_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset register values
    push_req(OP_CODE, 2'd3, 32'h0);             // zero right after reset: repeat
    push_req(OP_CODE, 2'd0, 32'hFFFF_FFFF);     // empty table: no match
    push_req(OP_LEARN, 2'd0, 32'h0);
    push_req(OP_CODE, 2'd1, 32'hFFFF_FFFF);     // repeat while learning
    push_req(OP_CODE, 2'd2, 32'h0);             // learned into channel 0
    push_req(OP_LEARN, 2'd3, 32'hFFFF_FFFF);
    push_req(OP_CODE, 2'd0, 32'hFFFF_FFFF);     // learned into channel 3
    push_req(OP_CODE, 2'd0, 32'h0);             // match channel 0
    push_req(OP_LEARN, 2'd1, 32'h0);
    push_req(OP_LEARN, 2'd2, 32'h0);            // replaces the learn on 1
    push_req(OP_CODE, 2'd0, 32'hFFFF_FFFF);     // learned into channel 2
    push_req(OP_CODE, 2'd0, 32'hFFFF_FFFF);     // repeat in normal mode
    push_req(OP_CODE, 2'd0, 32'h0);
    push_req(OP_CODE, 2'd0, 32'hFFFF_FFFF);     // match channels 2 and 3
    push_req(OP_LEARN, 2'd2, 32'h0);
    push_req(OP_CODE, 2'd0, 32'h5A5A_5A5A);
    push_req(OP_LEARN, 2'd2, 32'h0);
    push_req(OP_CODE, 2'd0, 32'hFFFF_FFFF);     // already known
    push_req(OP_DELETE, 2'd0, 32'hFFFF_FFFF);
    push_req(OP_CODE, 2'd0, 32'hA5A5_A5A5);     // delete not found
    push_req(OP_DELETE, 2'd0, 32'h0);
    push_req(OP_CODE, 2'd0, 32'h0);             // deleted
    push_req(OP_DELETE_ALL, 2'd3, 32'hFFFF_FFFF);
    push_req(OP_CODE, 2'd0, 32'h5A5A_5A5A);     // nothing left to match
    push_req(OP_LEARN, 2'd1, 32'h0);
    push_ticks(1);

    // short timeout, narrow window
    set_regs(3'd4, 16'd3, 16'd5);
    gen_random(230, 8);
    // extremes low: one channel, no repeat filter, immediate timeout
    set_regs(3'd1, 16'd0, 16'd0);
    gen_random(230, 3);
    // extremes high: widest window and longest timeout
    set_regs(3'd2, 16'd65535, 16'd65535);
    gen_random(230, 8);
    set_regs(3'd3, 16'd10, 16'd20);
    gen_random(230, 25);
    // channel count above the channel total is clipped
    set_regs(3'd7, 16'd1, 16'd2);
    gen_random(230, 5);
    // channel count zero searches nothing
    set_regs(3'd0, 16'd5, 16'd12);
    gen_random(60, 15);
    set_regs(3'd4, 16'd2, 16'd6);
    gen_random(60, 8);

    wait_drained();
    if (err_count == 0) begin
      $display("learned_code_table_matcher test passed");
    end else begin
      $display("learned_code_table_matcher test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : run_limit
    #2_000_000;
    $display("learned_code_table_matcher test failed");
    $finish;
  end

endmodule
